// ===== rtl/pcf_pkg.sv =====
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared widths, register indexes, sequencer states and saturation helper
// for the pivoted Cholesky factor engine.
// ----------------------------------------------------------------------------
package pcf_pkg;

  // default largest matrix order
  localparam int MAX_ORDER_DEF = 8;

  // payload widths
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 3;
  localparam int RANK_W    = 4;
  localparam int SIZE_W    = 4;
  localparam int TOL_W     = 31;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_TOL   = 1'b1;

  // square root and divider sizing
  localparam int SQ_W      = 48;
  localparam int SQ_STEPS  = 24;
  localparam int ROOT_W    = 24;
  localparam int DIV_STEPS = 48;
  localparam int CNT_W     = 6;
  localparam int FRAC_W    = 16;

  // sequencer states
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_INIT,
    ST_STEP,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_CHECK,
    ST_PERM_SWAP,
    ST_SWC_A,
    ST_SWC_B,
    ST_SWC_C,
    ST_SWC_D,
    ST_SWR_A,
    ST_SWR_B,
    ST_SWR_C,
    ST_SWR_D,
    ST_SQRT,
    ST_SC_RD,
    ST_SC_LD,
    ST_DIV,
    ST_SC_FIX,
    ST_SC_WR,
    ST_UP_CHK,
    ST_UP_A,
    ST_UP_B,
    ST_UP_C,
    ST_UP_D,
    ST_UP_E,
    ST_UP_F,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_OUT
  } state_t;

  // clamp a wide signed value to the 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      return DATA_W'(hi);
    end else if (v < lo) begin
      return DATA_W'(lo);
    end
    return DATA_W'(v);
  endfunction

endpackage

// ===== rtl/pcf_if.sv =====
// ----------------------------------------------------------------------------
// pcf_if
// Valid/ready channel interfaces: matrix input, factor output and
// register write port.
// ----------------------------------------------------------------------------
interface pcf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcf_pkg::DATA_W-1:0]   element;
  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface pcf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcf_pkg::DATA_W-1:0]   factor_value;
  logic [pcf_pkg::IDX_W-1:0]           row_index;
  logic [pcf_pkg::IDX_W-1:0]           col_index;
  logic [pcf_pkg::IDX_W-1:0]           perm_entry;
  logic [pcf_pkg::RANK_W-1:0]          rank_found;
  logic                                last_out;
  modport source (output valid, output factor_value, output row_index,
                  output col_index, output perm_entry, output rank_found,
                  output last_out, input ready);
  modport sink   (input valid, input factor_value, input row_index,
                  input col_index, input perm_entry, input rank_found,
                  input last_out, output ready);
endinterface

interface pcf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pcf_pkg::CFG_IDX_W-1:0]       index;
  logic [pcf_pkg::DATA_W-1:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pivoted_cholesky_factor_top.sv =====
// Loading accepts one element per cycle while in_ch.valid holds; n*n elements fill the matrix.
// Factoring then runs under one sequencer over a single-port matrix memory:
// each step scans the remaining diagonal, swaps a column and a row, takes a
// root, divides each subcolumn element (bit-serial) and updates the trailing elements.
// Emission reads, loads and presents one factor element at a time, holding it until the sink is ready.
// Synchronous active-low reset: loading state, identity permutation, size 8.
// ----------------------------------------------------------------------------
// pivoted_cholesky_factor_top
// Right-looking Cholesky with diagonal pivoting on a Q16.16 matrix, built
// around one memory port, a bit-serial square root, a bit-serial divider
// and one multiplier.
// ----------------------------------------------------------------------------
module pivoted_cholesky_factor_top #(
  parameter int MAX_ORDER = pcf_pkg::MAX_ORDER_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  pcf_in_if.sink          in_ch,
  pcf_out_if.source       out_ch,
  pcf_cfg_if.sink         cfg_ch
);

  localparam int IW       = $clog2(MAX_ORDER);
  localparam int CW       = $clog2(MAX_ORDER + 1);
  localparam int AW       = 2 * IW;
  localparam int DEPTH    = 1 << AW;
  localparam int DW       = pcf_pkg::DATA_W;
  localparam int ROOT_W_L = pcf_pkg::ROOT_W;

  // matrix memory, row-major address
  logic signed [DW-1:0] mem [DEPTH];
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic signed [DW-1:0] wdata;
  logic                 we;
  logic signed [DW-1:0] rdata_r;

  pcf_pkg::state_t state_r, state_nxt;

  logic [pcf_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [pcf_pkg::TOL_W-1:0]  tol_r, tol_nxt;
  logic [CW-1:0] ld_row_r, ld_row_nxt, ld_col_r, ld_col_nxt;
  logic [CW-1:0] i_r, i_nxt, p_r, p_nxt, piv_r, piv_nxt;
  logic [CW-1:0] rr_r, rr_nxt, cc_r, cc_nxt, rank_r, rank_nxt;
  logic signed [DW-1:0] dmax_r, dmax_nxt, t1_r, t1_nxt;
  logic signed [DW-1:0] a_r, a_nxt, b_r, b_nxt, d_r, d_nxt, q_r, q_nxt;
  logic signed [63:0]   prod_r, prod_nxt;
  logic [pcf_pkg::SQ_W-1:0] sq_x_r, sq_x_nxt, sq_res_r, sq_res_nxt;
  logic [pcf_pkg::SQ_W-1:0] sq_bit_r, sq_bit_nxt;
  logic [pcf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [pcf_pkg::ROOT_W:0] rem_r, rem_nxt;
  logic [pcf_pkg::DIV_STEPS-1:0] dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic neg_r, neg_nxt;
  logic [IW-1:0] perm_r [MAX_ORDER];
  logic [IW-1:0] perm_nxt [MAX_ORDER];
  logic [IW-1:0] ptmp_r, ptmp_nxt;
  logic [IW-1:0] perm_rd_idx;
  logic [IW-1:0] perm_rd;

  logic signed [DW-1:0]     out_val_r, out_val_nxt;
  logic [IW-1:0]            out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [IW-1:0]            out_perm_r, out_perm_nxt;
  logic [CW-1:0]            out_rank_r, out_rank_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [CW-1:0] n_eff;
  logic [ROOT_W_L-1:0] g;

  // scratch values for the datapath
  logic [pcf_pkg::SQ_W-1:0]     sq_sum;
  logic [pcf_pkg::ROOT_W:0]     rem_sh;
  logic [DW-1:0]                a_mag;
  logic signed [63:0]           prod_adj;
  logic signed [63:0]           div_signed;
  logic signed [63:0]           diff;
  logic                         in_xfer;
  logic                         cfg_xfer;
  logic                         out_xfer;

  function automatic logic [AW-1:0] maddr(input logic [CW-1:0] row,
                                          input logic [CW-1:0] col);
    return {row[IW-1:0], col[IW-1:0]};
  endfunction

  // effective order after clamping
  always_comb begin
    if (size_r == '0) begin
      n_eff = CW'(1);
    end else if (size_r > pcf_pkg::SIZE_W'(MAX_ORDER)) begin
      n_eff = CW'(MAX_ORDER);
    end else begin
      n_eff = CW'(size_r);
    end
  end

  assign g          = sq_res_r[ROOT_W_L-1:0];
  assign perm_rd    = perm_r[perm_rd_idx];
  assign in_ch.ready  = (state_r == pcf_pkg::ST_LOAD);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign cfg_xfer   = cfg_ch.valid && cfg_ch.ready;
  assign out_xfer   = out_valid_r && out_ch.ready;

  // output port drive
  assign out_ch.valid        = out_valid_r;
  assign out_ch.factor_value = out_val_r;
  assign out_ch.row_index    = pcf_pkg::IDX_W'(out_row_r);
  assign out_ch.col_index    = pcf_pkg::IDX_W'(out_col_r);
  assign out_ch.perm_entry   = pcf_pkg::IDX_W'(out_perm_r);
  assign out_ch.rank_found   = pcf_pkg::RANK_W'(out_rank_r);
  assign out_ch.last_out     = out_last_r;

  // sequencer: next state and datapath
  always_comb begin
    state_nxt   = state_r;
    size_nxt    = size_r;
    tol_nxt     = tol_r;
    ld_row_nxt  = ld_row_r;
    ld_col_nxt  = ld_col_r;
    i_nxt       = i_r;
    p_nxt       = p_r;
    piv_nxt     = piv_r;
    rr_nxt      = rr_r;
    cc_nxt      = cc_r;
    rank_nxt    = rank_r;
    dmax_nxt    = dmax_r;
    t1_nxt      = t1_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    d_nxt       = d_r;
    q_nxt       = q_r;
    prod_nxt    = prod_r;
    sq_x_nxt    = sq_x_r;
    sq_res_nxt  = sq_res_r;
    sq_bit_nxt  = sq_bit_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    dvd_nxt     = dvd_r;
    quo_nxt     = quo_r;
    neg_nxt     = neg_r;
    perm_nxt    = perm_r;
    ptmp_nxt    = ptmp_r;
    perm_rd_idx = cc_r[IW-1:0];
    out_val_nxt   = out_val_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_perm_nxt  = out_perm_r;
    out_rank_nxt  = out_rank_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    raddr = '0;
    waddr = '0;
    wdata = '0;
    we    = 1'b0;
    sq_sum   = sq_res_r + sq_bit_r;
    rem_sh   = {rem_r[ROOT_W_L-1:0], dvd_r[pcf_pkg::DIV_STEPS-1]};
    a_mag    = rdata_r[DW-1] ? DW'(-rdata_r) : DW'(rdata_r);
    prod_adj = prod_r + (prod_r[63] ? 64'sd65535 : 64'sd0);
    div_signed = neg_r ? -$signed({16'h0, quo_r}) : $signed({16'h0, quo_r});
    diff     = 64'(d_r) - 64'(q_r);

    unique case (state_r)
      // matrix fill, column-major
      pcf_pkg::ST_LOAD: begin
        if (in_xfer) begin
          we    = 1'b1;
          waddr = maddr(ld_row_r, ld_col_r);
          wdata = in_ch.element;
          if (ld_row_r + CW'(1) == n_eff) begin
            ld_row_nxt = '0;
            if (ld_col_r + CW'(1) == n_eff) begin
              ld_col_nxt = '0;
              state_nxt  = pcf_pkg::ST_INIT;
            end else begin
              ld_col_nxt = ld_col_r + CW'(1);
            end
          end else begin
            ld_row_nxt = ld_row_r + CW'(1);
          end
        end
      end
      pcf_pkg::ST_INIT: begin
        for (int k = 0; k < MAX_ORDER; k++) begin
          perm_nxt[k] = IW'(k);
        end
        i_nxt     = '0;
        state_nxt = pcf_pkg::ST_STEP;
      end
      pcf_pkg::ST_STEP: begin
        if (i_r == n_eff) begin
          rank_nxt  = i_r;
          rr_nxt    = '0;
          cc_nxt    = '0;
          state_nxt = pcf_pkg::ST_EM_RD;
        end else begin
          p_nxt     = i_r;
          state_nxt = pcf_pkg::ST_SCAN_RD;
        end
      end
      // pivot search over the remaining diagonal
      pcf_pkg::ST_SCAN_RD: begin
        raddr     = maddr(p_r, p_r);
        state_nxt = pcf_pkg::ST_SCAN_CMP;
      end
      pcf_pkg::ST_SCAN_CMP: begin
        if (p_r == i_r || dmax_r < rdata_r) begin
          dmax_nxt = rdata_r;
          piv_nxt  = p_r;
        end
        if (p_r + CW'(1) < n_eff) begin
          p_nxt     = p_r + CW'(1);
          state_nxt = pcf_pkg::ST_SCAN_RD;
        end else begin
          state_nxt = pcf_pkg::ST_CHECK;
        end
      end
      pcf_pkg::ST_CHECK: begin
        if (dmax_r < $signed({1'b0, tol_r})) begin
          rank_nxt  = i_r;
          rr_nxt    = '0;
          cc_nxt    = '0;
          state_nxt = pcf_pkg::ST_EM_RD;
        end else begin
          perm_rd_idx = i_r[IW-1:0];
          ptmp_nxt    = perm_rd;
          state_nxt   = pcf_pkg::ST_PERM_SWAP;
        end
      end
      pcf_pkg::ST_PERM_SWAP: begin
        perm_rd_idx = piv_r[IW-1:0];
        perm_nxt[i_r[IW-1:0]]   = perm_rd;
        perm_nxt[piv_r[IW-1:0]] = ptmp_r;
        rr_nxt    = '0;
        state_nxt = pcf_pkg::ST_SWC_A;
      end
      // column exchange
      pcf_pkg::ST_SWC_A: begin
        raddr     = maddr(rr_r, i_r);
        state_nxt = pcf_pkg::ST_SWC_B;
      end
      pcf_pkg::ST_SWC_B: begin
        t1_nxt    = rdata_r;
        raddr     = maddr(rr_r, piv_r);
        state_nxt = pcf_pkg::ST_SWC_C;
      end
      pcf_pkg::ST_SWC_C: begin
        we        = 1'b1;
        waddr     = maddr(rr_r, i_r);
        wdata     = rdata_r;
        state_nxt = pcf_pkg::ST_SWC_D;
      end
      pcf_pkg::ST_SWC_D: begin
        we    = 1'b1;
        waddr = maddr(rr_r, piv_r);
        wdata = t1_r;
        if (rr_r + CW'(1) < n_eff) begin
          rr_nxt    = rr_r + CW'(1);
          state_nxt = pcf_pkg::ST_SWC_A;
        end else begin
          cc_nxt    = '0;
          state_nxt = pcf_pkg::ST_SWR_A;
        end
      end
      // row exchange
      pcf_pkg::ST_SWR_A: begin
        raddr     = maddr(i_r, cc_r);
        state_nxt = pcf_pkg::ST_SWR_B;
      end
      pcf_pkg::ST_SWR_B: begin
        t1_nxt    = rdata_r;
        raddr     = maddr(piv_r, cc_r);
        state_nxt = pcf_pkg::ST_SWR_C;
      end
      pcf_pkg::ST_SWR_C: begin
        we        = 1'b1;
        waddr     = maddr(i_r, cc_r);
        wdata     = rdata_r;
        state_nxt = pcf_pkg::ST_SWR_D;
      end
      pcf_pkg::ST_SWR_D: begin
        we    = 1'b1;
        waddr = maddr(piv_r, cc_r);
        wdata = t1_r;
        if (cc_r + CW'(1) < n_eff) begin
          cc_nxt    = cc_r + CW'(1);
          state_nxt = pcf_pkg::ST_SWR_A;
        end else begin
          sq_x_nxt   = {dmax_r, 16'h0};
          sq_res_nxt = '0;
          sq_bit_nxt = pcf_pkg::SQ_W'(1) << (pcf_pkg::SQ_W - 2);
          cnt_nxt    = '0;
          state_nxt  = pcf_pkg::ST_SQRT;
        end
      end
      // bit-serial integer square root, two radicand bits a cycle
      pcf_pkg::ST_SQRT: begin
        if (sq_x_r >= sq_sum) begin
          sq_x_nxt   = sq_x_r - sq_sum;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        cnt_nxt    = cnt_r + pcf_pkg::CNT_W'(1);
        if (cnt_r == pcf_pkg::CNT_W'(pcf_pkg::SQ_STEPS - 1)) begin
          rr_nxt    = i_r;
          state_nxt = pcf_pkg::ST_SC_RD;
        end
      end
      // subcolumn scaling by the root
      pcf_pkg::ST_SC_RD: begin
        raddr     = maddr(rr_r, i_r);
        state_nxt = pcf_pkg::ST_SC_LD;
      end
      pcf_pkg::ST_SC_LD: begin
        neg_nxt = rdata_r[DW-1];
        dvd_nxt = {a_mag, 16'h0};
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = '0;
        if (g == '0) begin
          if (rdata_r > 0) begin
            q_nxt = pcf_pkg::sat32(64'sh7FFF_FFFF);
          end else if (rdata_r < 0) begin
            q_nxt = pcf_pkg::sat32(-64'sh8000_0000);
          end else begin
            q_nxt = '0;
          end
          state_nxt = pcf_pkg::ST_SC_WR;
        end else begin
          state_nxt = pcf_pkg::ST_DIV;
        end
      end
      // restoring divide, one quotient bit a cycle
      pcf_pkg::ST_DIV: begin
        dvd_nxt = dvd_r << 1;
        if (rem_sh >= {1'b0, g}) begin
          rem_nxt = rem_sh - {1'b0, g};
          quo_nxt = {quo_r[pcf_pkg::DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[pcf_pkg::DIV_STEPS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + pcf_pkg::CNT_W'(1);
        if (cnt_r == pcf_pkg::CNT_W'(pcf_pkg::DIV_STEPS - 1)) begin
          state_nxt = pcf_pkg::ST_SC_FIX;
        end
      end
      pcf_pkg::ST_SC_FIX: begin
        q_nxt     = pcf_pkg::sat32(div_signed);
        state_nxt = pcf_pkg::ST_SC_WR;
      end
      pcf_pkg::ST_SC_WR: begin
        we    = 1'b1;
        waddr = maddr(rr_r, i_r);
        wdata = q_r;
        if (rr_r + CW'(1) < n_eff) begin
          rr_nxt    = rr_r + CW'(1);
          state_nxt = pcf_pkg::ST_SC_RD;
        end else begin
          cc_nxt    = i_r + CW'(1);
          rr_nxt    = i_r + CW'(1);
          state_nxt = pcf_pkg::ST_UP_CHK;
        end
      end
      // trailing submatrix update, column by column
      pcf_pkg::ST_UP_CHK: begin
        if (cc_r >= n_eff) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = pcf_pkg::ST_STEP;
        end else if (rr_r >= n_eff) begin
          cc_nxt = cc_r + CW'(1);
          rr_nxt = i_r + CW'(1);
        end else begin
          state_nxt = pcf_pkg::ST_UP_A;
        end
      end
      pcf_pkg::ST_UP_A: begin
        raddr     = maddr(rr_r, i_r);
        state_nxt = pcf_pkg::ST_UP_B;
      end
      pcf_pkg::ST_UP_B: begin
        a_nxt     = rdata_r;
        raddr     = maddr(cc_r, i_r);
        state_nxt = pcf_pkg::ST_UP_C;
      end
      pcf_pkg::ST_UP_C: begin
        b_nxt     = rdata_r;
        raddr     = maddr(rr_r, cc_r);
        state_nxt = pcf_pkg::ST_UP_D;
      end
      pcf_pkg::ST_UP_D: begin
        d_nxt     = rdata_r;
        prod_nxt  = 64'(a_r) * 64'(b_r);
        state_nxt = pcf_pkg::ST_UP_E;
      end
      pcf_pkg::ST_UP_E: begin
        q_nxt     = pcf_pkg::sat32(prod_adj >>> pcf_pkg::FRAC_W);
        state_nxt = pcf_pkg::ST_UP_F;
      end
      pcf_pkg::ST_UP_F: begin
        we        = 1'b1;
        waddr     = maddr(rr_r, cc_r);
        wdata     = pcf_pkg::sat32(diff);
        rr_nxt    = rr_r + CW'(1);
        state_nxt = pcf_pkg::ST_UP_CHK;
      end
      // factor emission, column-major
      pcf_pkg::ST_EM_RD: begin
        raddr     = maddr(rr_r, cc_r);
        state_nxt = pcf_pkg::ST_EM_LD;
      end
      pcf_pkg::ST_EM_LD: begin
        out_val_nxt   = (rr_r >= cc_r && cc_r < rank_r) ? rdata_r : '0;
        out_row_nxt   = rr_r[IW-1:0];
        out_col_nxt   = cc_r[IW-1:0];
        out_perm_nxt  = perm_rd;
        out_rank_nxt  = rank_r;
        out_last_nxt  = (rr_r + CW'(1) == n_eff) && (cc_r + CW'(1) == n_eff);
        out_valid_nxt = 1'b1;
        state_nxt     = pcf_pkg::ST_EM_OUT;
      end
      pcf_pkg::ST_EM_OUT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            ld_row_nxt = '0;
            ld_col_nxt = '0;
            state_nxt  = pcf_pkg::ST_LOAD;
          end else if (rr_r + CW'(1) == n_eff) begin
            rr_nxt    = '0;
            cc_nxt    = cc_r + CW'(1);
            state_nxt = pcf_pkg::ST_EM_RD;
          end else begin
            rr_nxt    = rr_r + CW'(1);
            state_nxt = pcf_pkg::ST_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = pcf_pkg::ST_LOAD;
      end
    endcase

    // register writes; a size write resets the load counters to the first element
    if (cfg_xfer) begin
      unique case (cfg_ch.index)
        pcf_pkg::REG_MATRIX_SIZE: begin
          size_nxt   = cfg_ch.data[pcf_pkg::SIZE_W-1:0];
          ld_row_nxt = '0;
          ld_col_nxt = '0;
        end
        pcf_pkg::REG_PIVOT_TOL: begin
          tol_nxt = cfg_ch.data[pcf_pkg::TOL_W-1:0];
        end
        default: begin
          tol_nxt = tol_r;
        end
      endcase
    end
  end

  // matrix memory port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcf_pkg::ST_LOAD;
      size_r      <= pcf_pkg::SIZE_W'(pcf_pkg::MAX_ORDER_DEF);
      tol_r       <= '0;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_ORDER; k++) begin
        perm_r[k] <= IW'(k);
      end
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      tol_r       <= tol_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
      perm_r      <= perm_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    p_r        <= p_nxt;
    piv_r      <= piv_nxt;
    rr_r       <= rr_nxt;
    cc_r       <= cc_nxt;
    dmax_r     <= dmax_nxt;
    t1_r       <= t1_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    d_r        <= d_nxt;
    q_r        <= q_nxt;
    prod_r     <= prod_nxt;
    sq_x_r     <= sq_x_nxt;
    sq_res_r   <= sq_res_nxt;
    sq_bit_r   <= sq_bit_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    quo_r      <= quo_nxt;
    neg_r      <= neg_nxt;
    ptmp_r     <= ptmp_nxt;
    out_val_r  <= out_val_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_perm_r <= out_perm_nxt;
    out_rank_r <= out_rank_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
